@@ rtl/length_prefixed_link_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// Length-prefixed link deframer: assertion macros
// Concurrent assertion wrappers clocked on clk_i; LPD_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_LINK_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_LINK_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only
`define LPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every edge, reset included
`define LPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPD_ASSERT(label, prop, msg)
`define LPD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/lpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the link deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpd_pkg;

  localparam logic [3:0]  HdrBytes     = 4'd8;
  localparam logic [15:0] TimeoutMin   = 16'd10;
  localparam logic [15:0] TimeoutReset = 16'd60;
  localparam logic [15:0] KaReset      = 16'd20;      // 60 / 3
  localparam logic [23:0] MaxPayReset  = 24'd1500000;
  localparam logic [16:0] CntMax       = 17'h1FFFF;
  // floor(x / 3) == (x * 43691) >> 17 for any 16-bit x
  localparam logic [16:0] KaRecip      = 17'd43691;
  localparam int          KaShift      = 17;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MAXPAY  = 1'b1;

  localparam logic [2:0] ACT_RX_BYTE  = 3'd0;
  localparam logic [2:0] ACT_TICK     = 3'd1;
  localparam logic [2:0] ACT_TX_PROG  = 3'd2;
  localparam logic [2:0] ACT_CONNECT  = 3'd3;
  localparam logic [2:0] ACT_DROP     = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_HDR  = 3'b010,
    MODE_DATA = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    EV_BYTE      = 3'd0,
    EV_EMPTY     = 3'd1,
    EV_OVERSIZE  = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_KEEPALIVE = 3'd4,
    EV_REGISTER  = 3'd5
  } event_e;

  typedef struct packed {
    logic        valid;
    event_e      ev;
    logic [31:0] msg_type;
    logic [7:0]  data;
    logic        last;
  } res_t;

endpackage

@@ rtl/length_prefixed_link_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_link_deframer
// Link supervisor and deframer for messages with an 8-byte type/length header.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle for as long as results are drained; every
// item passes an input register, the state update in lpd_step and an output
// register.
// The output register frees its slot in the cycle it is read, so a stalled
// consumer holds off input only once the input register is also occupied.
// Config writes (timeout_secs, max_payload) take effect on the next edge.
`timescale 1ns / 1ps

module length_prefixed_link_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   action_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         tx_idle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   event_res_o,
  output logic [31:0]                  msg_type_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         last_o
);
  import lpd_pkg::*;

  logic        in_vld_q;
  logic [2:0]  action_q;
  logic [7:0]  rx_byte_q;
  logic        tx_idle_q;
  logic        out_vld_q;
  logic [2:0]  ev_q;
  logic [31:0] type_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic        advance;
  res_t        res;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q  <= action_i;
      rx_byte_q <= rx_byte_i;
      tx_idle_q <= tx_idle_i;
    end
  end

  lpd_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .action_i    (action_q),
    .rx_byte_i   (rx_byte_q),
    .tx_idle_i   (tx_idle_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      ev_q   <= res.ev;
      type_q <= res.msg_type;
      data_q <= res.data;
      last_q <= res.last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = ev_q;
  assign msg_type_o     = type_q;
  assign payload_byte_o = data_q;
  assign last_o         = last_q;

endmodule

@@ rtl/lpd_step.sv @@
// ----------------------------------------------------------------------------
// lpd_step
// Link state, header/payload tracking, silence counters and config registers.
// Processes one registered item per cycle while step_i is high and produces at most one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_link_deframer_defines.svh"

module lpd_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [2:0]                  action_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        tx_idle_i,
  input  logic                        cfg_we_i,
  input  logic [lpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output lpd_pkg::res_t               res_o
);
  import lpd_pkg::*;

  mode_e       mode_q, mode_d;
  logic [63:0] shift_q, shift_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [23:0] left_q, left_d;
  logic [31:0] type_q, type_d;
  logic [16:0] rd_q, rd_d;
  logic [16:0] wr_q, wr_d;

  // Config is held pre-digested: clamped limit and keepalive threshold
  logic [15:0] lim_q;
  logic [15:0] ka_q;
  logic [23:0] maxpay_q;

  logic [15:0] lim_w;
  logic [32:0] ka_prod;

  logic        active;
  logic [63:0] shifted;
  logic [3:0]  cnt_inc;
  logic [23:0] left_dec;
  logic [16:0] rd_inc;
  logic [16:0] wr_inc;
  res_t        res;

  assign lim_w   = (cfg_wdata_i[15:0] < TimeoutMin) ? TimeoutMin : cfg_wdata_i[15:0];
  assign ka_prod = 33'(lim_w) * 33'(KaRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q    <= TimeoutReset;
      ka_q     <= KaReset;
      maxpay_q <= MaxPayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIMEOUT: begin
          lim_q <= lim_w;
          ka_q  <= ka_prod[KaShift+15:KaShift];
        end
        REG_MAXPAY: maxpay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign active   = (mode_q == MODE_HDR) || (mode_q == MODE_DATA);
  assign shifted  = {shift_q[55:0], rx_byte_i};
  assign cnt_inc  = cnt_q + 4'd1;
  assign left_dec = left_q - 24'd1;
  assign rd_inc   = (rd_q == CntMax) ? rd_q : rd_q + 17'd1;
  assign wr_inc   = (wr_q == CntMax) ? wr_q : wr_q + 17'd1;

  always_comb begin
    mode_d  = mode_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    type_d  = type_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    res     = '0;
    if (step_i) begin
      case (action_i)
        ACT_RX_BYTE: begin
          if (active) begin
            rd_d = '0;
            if (mode_q == MODE_HDR) begin
              if (cnt_inc == HdrBytes) begin
                shift_d      = '0;
                cnt_d        = '0;
                type_d       = shifted[63:32];
                res.msg_type = shifted[63:32];
                if (shifted[31:0] == 32'd0) begin
                  res.valid = 1'b1;
                  res.ev    = EV_EMPTY;
                  res.last  = 1'b1;
                end else if (shifted[31:0] > {8'd0, maxpay_q}) begin
                  mode_d    = MODE_IDLE;
                  res.valid = 1'b1;
                  res.ev    = EV_OVERSIZE;
                end else begin
                  left_d = shifted[23:0];
                  mode_d = MODE_DATA;
                end
              end else begin
                shift_d = shifted;
                cnt_d   = cnt_inc;
              end
            end else begin
              left_d       = left_dec;
              res.valid    = 1'b1;
              res.ev       = EV_BYTE;
              res.msg_type = type_q;
              res.data     = rx_byte_i;
              res.last     = (left_dec == 24'd0);
              if (left_dec == 24'd0) begin
                mode_d  = MODE_HDR;
                shift_d = '0;
                cnt_d   = '0;
              end
            end
          end
        end
        ACT_TICK: begin
          if (active) begin
            rd_d = rd_inc;
            wr_d = wr_inc;
            if (rd_inc > {1'b0, lim_q}) begin
              mode_d    = MODE_IDLE;
              res.valid = 1'b1;
              res.ev    = EV_TIMEOUT;
            end else if (wr_inc > {1'b0, ka_q} && tx_idle_i) begin
              res.valid = 1'b1;
              res.ev    = EV_KEEPALIVE;
            end
          end
        end
        ACT_TX_PROG: begin
          if (active) wr_d = '0;
        end
        ACT_CONNECT: begin
          mode_d    = MODE_HDR;
          shift_d   = '0;
          cnt_d     = '0;
          left_d    = '0;
          type_d    = '0;
          rd_d      = '0;
          wr_d      = '0;
          res.valid = 1'b1;
          res.ev    = EV_REGISTER;
        end
        ACT_DROP: mode_d = MODE_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      type_q  <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
    end else begin
      mode_q  <= mode_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      type_q  <= type_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  assign res_o = res;

  `LPD_ASSERT_ALWAYS(a_hdr_cnt_range, cnt_q < HdrBytes, "header count past header size")
  `LPD_ASSERT(a_data_left_nonzero, (mode_q == MODE_DATA) |-> (left_q != 24'd0),
              "data mode with no payload left")
  `LPD_ASSERT(a_timeout_idles, (res.valid && res.ev == EV_TIMEOUT) |=> (mode_q == MODE_IDLE),
              "link still active after timeout")
  `LPD_ASSERT(a_last_rearms, (res.valid && res.ev == EV_BYTE && res.last)
              |=> (mode_q == MODE_HDR && cnt_q == 4'd0), "header not rearmed after last byte")
  `LPD_ASSERT(a_ka_below_lim, ka_q < lim_q, "keepalive threshold not below timeout")

endmodule

@@ dv/tb_length_prefixed_link_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_length_prefixed_link_deframer
// Drives connect, byte, tick, transmit and drop items into the link deframer
// and checks every result against a cycle-free model of the link that is kept
// in step with the accepted items. A short directed part covers the edges,
// then random message streams run under several register settings, and a
// closing tick run under the largest timeout lets the write silence grow
// while reads keep the link alive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_length_prefixed_link_deframer;
  import lpd_pkg::*;

  localparam int KaDiv     = 3;
  localparam int WdLimit   = 2000;
  localparam int HoldLen   = 300;
  localparam int SoakTicks = 50;

  typedef struct packed {
    event_e      ev;
    logic [31:0] msg_type;
    logic [7:0]  payload_byte;
    logic        last;
  } link_event_t;

  // Tracks the link as the block should see it and queues the events it owes.
  class deframe_tracker;
    logic [15:0]  timeout_secs;
    logic [23:0]  max_payload;
    mode_e        mode;
    logic [63:0]  hdr_shift;
    logic [3:0]   hdr_count;
    logic [23:0]  bytes_left;
    logic [31:0]  cur_type;
    logic [16:0]  since_read;
    logic [16:0]  since_write;
    link_event_t  owed_events[$];
    int           mismatches;

    function new();
      timeout_secs = TimeoutReset;
      max_payload  = MaxPayReset;
      mode         = MODE_IDLE;
      hdr_shift    = '0;
      hdr_count    = '0;
      bytes_left   = '0;
      cur_type     = '0;
      since_read   = '0;
      since_write  = '0;
      mismatches   = 0;
    endfunction

    function bit active();
      return mode == MODE_HDR || mode == MODE_DATA;
    endfunction

    function int pending();
      return owed_events.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == REG_TIMEOUT) timeout_secs = val[15:0];
      else if (idx == REG_MAXPAY) max_payload = val;
    endfunction

    function void owe(event_e ev, logic [31:0] t, logic [7:0] b, logic l);
      link_event_t e;
      e.ev = ev;
      e.msg_type = t;
      e.payload_byte = b;
      e.last = l;
      owed_events.push_back(e);
    endfunction

    function void restart_header();
      mode      = MODE_HDR;
      hdr_shift = '0;
      hdr_count = '0;
    endfunction

    function void take_item(logic [2:0] act, logic [7:0] b, logic txi);
      logic [31:0] hdr_type;
      logic [31:0] hdr_len;
      logic [16:0] lim;
      logic        fin;
      case (act)
        ACT_RX_BYTE: begin
          if (!active()) return;
          since_read = '0;
          if (mode == MODE_HDR) begin
            hdr_shift = {hdr_shift[55:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count < HdrBytes) return;
            hdr_type  = hdr_shift[63:32];
            hdr_len   = hdr_shift[31:0];
            hdr_shift = '0;
            hdr_count = '0;
            cur_type  = hdr_type;
            if (hdr_len == 0) begin
              owe(EV_EMPTY, hdr_type, 8'h00, 1'b1);
            end else if (hdr_len > {8'h00, max_payload}) begin
              mode = MODE_IDLE;
              owe(EV_OVERSIZE, hdr_type, 8'h00, 1'b0);
            end else begin
              bytes_left = hdr_len[23:0];
              mode = MODE_DATA;
            end
          end else begin
            bytes_left = bytes_left - 24'd1;
            fin = (bytes_left == 0);
            if (fin) restart_header();
            owe(EV_BYTE, cur_type, b, fin);
          end
        end
        ACT_TICK: begin
          if (!active()) return;
          if (since_read != CntMax) since_read++;
          if (since_write != CntMax) since_write++;
          lim = (timeout_secs < TimeoutMin) ? {1'b0, TimeoutMin} : {1'b0, timeout_secs};
          if (since_read > lim) begin
            mode = MODE_IDLE;
            owe(EV_TIMEOUT, '0, '0, 1'b0);
          end else if (since_write > lim / KaDiv && txi) begin
            owe(EV_KEEPALIVE, '0, '0, 1'b0);
          end
        end
        ACT_TX_PROG: begin
          if (active()) since_write = '0;
        end
        ACT_CONNECT: begin
          restart_header();
          bytes_left  = '0;
          cur_type    = '0;
          since_read  = '0;
          since_write = '0;
          owe(EV_REGISTER, '0, '0, 1'b0);
        end
        ACT_DROP: mode = MODE_IDLE;
        default: ;
      endcase
    endfunction

    function void match_result(logic [2:0] ev, logic [31:0] t, logic [7:0] b, logic l);
      link_event_t e;
      if (owed_events.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing owed: event_res=%0d msg_type=%h byte=%h last=%b",
                 $time, ev, t, b, l);
        return;
      end
      e = owed_events.pop_front();
      if (ev !== e.ev) begin
        mismatches++;
        $display("%0t: event_res expected %0d, got %0d", $time, e.ev, ev);
      end
      if (t !== e.msg_type) begin
        mismatches++;
        $display("%0t: msg_type expected %h, got %h", $time, e.msg_type, t);
      end
      if (b !== e.payload_byte) begin
        mismatches++;
        $display("%0t: payload_byte expected %h, got %h", $time, e.payload_byte, b);
      end
      if (l !== e.last) begin
        mismatches++;
        $display("%0t: last expected %b, got %b", $time, e.last, l);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [2:0]          action_i;
  logic [7:0]          rx_byte_i;
  logic                tx_idle_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          event_res_o;
  logic [31:0]         msg_type_o;
  logic [7:0]          payload_byte_o;
  logic                last_o;

  deframe_tracker link_model = new();
  int  items_sent;
  int  quiet_cycles;
  bit  quiet;
  bit  hold_req;

  length_prefixed_link_deframer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .tx_idle_i      (tx_idle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .msg_type_o     (msg_type_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Result side: random back-pressure plus one long hold when requested.
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        out_ready_i <= 1'b0;
        hold_left  = HoldLen - 1;
        hold_taken = 1'b1;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 6);
      end
      if (!hold_req) hold_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      link_model.match_result(event_res_o, msg_type_o, payload_byte_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WdLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WdLimit);
      $display("FAIL length_prefixed_link_deframer");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [7:0] b, input logic txi);
    int gap;
    gap = (quiet || $urandom_range(99) >= 6) ? 0 : $urandom_range(4, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    tx_idle_i  <= txi;
    do @(posedge clk_i); while (!in_ready_o);
    link_model.take_item(act, b, txi);
    items_sent++;
  endtask

  task automatic send_rand(input logic [2:0] act);
    send_item(act, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_header(input logic [31:0] mtype, input logic [31:0] len);
    logic [63:0] hdr;
    hdr = {mtype, len};
    for (int i = 0; i < HdrBytes; i++) send_item(ACT_RX_BYTE, hdr[63-8*i -: 8], 1'($urandom));
  endtask

  // Sender stops and waits until the block has handed over everything owed.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (link_model.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    link_model.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] tmo, input logic [23:0] maxpay);
    drain();
    cfg_write(REG_TIMEOUT, {8'h00, tmo});
    cfg_write(REG_MAXPAY, maxpay);
  endtask

  task automatic send_message();
    logic [31:0] mtype;
    logic [31:0] len;
    logic [31:0] mp;
    int          pick;
    int          n;
    if (link_model.mode != MODE_HDR) send_rand(ACT_CONNECT);
    mp   = {8'h00, link_model.max_payload};
    pick = $urandom_range(99);
    mtype = (pick < 10) ? 32'h0 : (pick < 20) ? 32'hFFFF_FFFF : $urandom;
    pick = $urandom_range(99);
    if (pick < 12) begin
      len = 0;
    end else if (pick < 27) begin
      len = $urandom;
      if (len <= mp) len = mp + 1 + $urandom_range(3);
    end else if (pick < 32) begin
      len = (mp <= 12) ? mp : $urandom_range(12, 1);
    end else begin
      len = $urandom_range(6, 1);
    end
    send_header(mtype, len);
    n = (len != 0 && len <= mp) ? int'(len) : 0;
    // occasionally cut the payload short so later headers land misaligned
    if (n != 0 && $urandom_range(99) < 4) n = $urandom_range(n - 1, 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) send_rand($urandom_range(1) ? ACT_TICK : ACT_TX_PROG);
      send_rand(ACT_RX_BYTE);
    end
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5) send_rand(3'($urandom_range(7)));
      else if (pick < 9) send_rand(ACT_CONNECT);
      else if (pick < 18) repeat ($urandom_range(14, 1)) send_rand(ACT_TICK);
      else if (pick < 22) send_rand(ACT_TX_PROG);
      else if (pick < 24) drain();
      else send_message();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_TIMEOUT;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_RX_BYTE;
    rx_byte_i   <= '0;
    tx_idle_i   <= 1'b0;
    items_sent   = 0;
    quiet_cycles = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle link ignores traffic, unknown actions are dropped; then an empty and an oversize header
    send_item(ACT_RX_BYTE, 8'hFF, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b1);
    send_item(ACT_TX_PROG, 8'h00, 1'b0);
    for (int a = ACT_DROP + 1; a < 8; a++) send_item(3'(a), 8'hA5, 1'b1);
    send_item(ACT_CONNECT, 8'h00, 1'b0);
    send_header(32'hFFFF_FFFF, 32'h0);
    send_header(32'h1234_5678, 32'hFFFF_FFFF);
    send_item(ACT_RX_BYTE, 8'h00, 1'b0);

    // timeout below the floor acts as 10: keepalive after 3 s, drop after 10 s
    configure(16'd0, 24'hFF_FFFF);
    send_item(ACT_CONNECT, 8'h00, 1'b1);
    repeat (3) send_item(ACT_TICK, 8'h00, 1'b0);
    send_item(ACT_TICK, 8'hFF, 1'b1);
    send_item(ACT_TX_PROG, 8'h00, 1'b1);
    send_item(ACT_TICK, 8'h00, 1'b1);
    repeat (7) send_item(ACT_TICK, 8'h00, 1'b0);

    configure(16'd10, 24'hFF_FFFF);
    run_traffic(300);
    configure(16'hFFFF, 24'd0);
    run_traffic(250);
    configure(16'd3, 24'd4);
    run_traffic(300);
    configure(TimeoutReset, MaxPayReset);
    quiet = 1'b1;
    run_traffic(300);
    quiet = 1'b0;
    configure(16'd12, 24'd8);
    hold_req = 1'b1;
    run_traffic(250);
    hold_req = 1'b0;

    // write silence keeps growing; reads keep the link alive
    configure(16'hFFFF, MaxPayReset);
    quiet = 1'b1;
    send_rand(ACT_CONNECT);
    repeat (SoakTicks) send_item(ACT_TICK, 8'($urandom), 1'b0);
    send_rand(ACT_RX_BYTE);
    repeat (SoakTicks) send_item(ACT_TICK, 8'($urandom), 1'b0);
    send_rand(ACT_RX_BYTE);
    repeat (3) send_item(ACT_TICK, 8'($urandom), 1'b1);
    quiet = 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    if (link_model.mismatches == 0 && link_model.pending() == 0)
      $display("PASS length_prefixed_link_deframer");
    else
      $display("FAIL length_prefixed_link_deframer");
    $finish;
  end

endmodule
